>>> sv/fdlcd_pkg.sv
// ----------------------------------------------------------------------------
// fdlcd_pkg
// shared types, symbol codes and segment table of the four digit lcd encoder
// ----------------------------------------------------------------------------
package fdlcd_pkg;

   localparam int unsigned NUM_POS = 4;
   localparam int unsigned NUM_COM = 4;
   localparam int unsigned WORD_W  = 8;
   localparam int unsigned NUM_SYM = 13;

   typedef enum logic [1:0] {
      OP_SET_DIGIT     = 2'd0,
      OP_SHOW_NUMBER   = 2'd1,
      OP_CLEAR         = 2'd2,
      OP_SET_CHARACTER = 2'd3
   } op_type;

   typedef logic [3:0]                sym_type;
   typedef logic [WORD_W-1:0]         word_type;
   typedef word_type [NUM_COM-1:0]    shadow_type;

   // one input transaction
   typedef struct packed {
      op_type      op;
      logic [1:0]  position;
      logic [15:0] value;
      logic        dot;
   } item_type;

   localparam sym_type SYM_BLANK = 4'd10;
   localparam sym_type SYM_DASH  = 4'd11;
   localparam sym_type SYM_POINT = 4'd12;

   localparam logic [15:0] SYM_LIMIT  = 16'd13;
   localparam logic [15:0] SHOW_LIMIT = 16'd9999;
   localparam logic [15:0] CHAR_ZERO  = 16'h0030;
   localparam logic [15:0] CHAR_NINE  = 16'h0039;
   localparam logic [15:0] CHAR_DASH  = 16'h002D;

   // 2-bit field per symbol and com step
   localparam logic [1:0] SEG_CODES [NUM_SYM][NUM_COM] = '{
      '{2'h1, 2'h3, 2'h2, 2'h3},
      '{2'h0, 2'h2, 2'h2, 2'h0},
      '{2'h1, 2'h1, 2'h3, 2'h2},
      '{2'h1, 2'h2, 2'h3, 2'h2},
      '{2'h0, 2'h2, 2'h3, 2'h1},
      '{2'h1, 2'h2, 2'h1, 2'h3},
      '{2'h1, 2'h3, 2'h1, 2'h3},
      '{2'h0, 2'h2, 2'h2, 2'h2},
      '{2'h1, 2'h3, 2'h3, 2'h3},
      '{2'h1, 2'h2, 2'h3, 2'h3},
      '{2'h0, 2'h0, 2'h0, 2'h0},
      '{2'h0, 2'h0, 2'h1, 2'h0},
      '{2'h2, 2'h0, 2'h0, 2'h0}
   };

   function automatic logic [1:0] seg_code(sym_type sym, logic [1:0] com);
      logic [1:0] code;
      code = 2'h0;
      if (sym < 4'(NUM_SYM)) begin
         code = SEG_CODES[sym][com];
      end
      return code;
   endfunction

endpackage

>>> sv/fdlcd_update.sv
// ----------------------------------------------------------------------------
// fdlcd_update
// next shadow words from the current shadow and one transaction
// ----------------------------------------------------------------------------
module fdlcd_update (
   input  fdlcd_pkg::item_type   item,
   input  fdlcd_pkg::shadow_type shadow_cur,
   output fdlcd_pkg::shadow_type shadow_nxt
);

   logic [13:0] num;
   logic [3:0]  dig0, dig1, dig2, dig3;
   logic [9:0]  rem0;
   logic [6:0]  rem1;
   logic [3:0]  rem2;

   fdlcd_pkg::sym_type sym [fdlcd_pkg::NUM_POS];
   logic               wr  [fdlcd_pkg::NUM_POS];
   logic               pnt [fdlcd_pkg::NUM_POS];
   fdlcd_pkg::sym_type char_sym;

   assign num = item.value[13:0];

   // decimal digits by compare and subtract, one digit per level
   always_comb begin
      dig0 = 4'd0;
      rem0 = num[9:0];
      for (int k = 1; k <= 9; k++) begin
         if (num >= 14'(k * 1000)) begin
            dig0 = 4'(k);
            rem0 = 10'(num - 14'(k * 1000));
         end
      end
   end

   always_comb begin
      dig1 = 4'd0;
      rem1 = rem0[6:0];
      for (int k = 1; k <= 9; k++) begin
         if (rem0 >= 10'(k * 100)) begin
            dig1 = 4'(k);
            rem1 = 7'(rem0 - 10'(k * 100));
         end
      end
   end

   always_comb begin
      dig2 = 4'd0;
      rem2 = rem1[3:0];
      for (int k = 1; k <= 9; k++) begin
         if (rem1 >= 7'(k * 10)) begin
            dig2 = 4'(k);
            rem2 = 4'(rem1 - 7'(k * 10));
         end
      end
   end

   assign dig3 = rem2;

   always_comb begin
      if (item.value >= fdlcd_pkg::CHAR_ZERO && item.value <= fdlcd_pkg::CHAR_NINE) begin
         char_sym = item.value[3:0];
      end else if (item.value == fdlcd_pkg::CHAR_DASH) begin
         char_sym = fdlcd_pkg::SYM_DASH;
      end else begin
         char_sym = fdlcd_pkg::SYM_BLANK;
      end
   end

   // per position: write enable, symbol and decimal point
   always_comb begin
      for (int p = 0; p < fdlcd_pkg::NUM_POS; p++) begin
         wr[p]  = 1'b0;
         sym[p] = fdlcd_pkg::SYM_BLANK;
         pnt[p] = 1'b0;
      end
      unique case (item.op)
         fdlcd_pkg::OP_SET_DIGIT: begin
            wr[item.position]  = 1'b1;
            sym[item.position] = (item.value >= fdlcd_pkg::SYM_LIMIT) ?
                                 fdlcd_pkg::SYM_BLANK : item.value[3:0];
            pnt[item.position] = item.dot;
         end
         fdlcd_pkg::OP_SHOW_NUMBER: begin
            for (int p = 0; p < fdlcd_pkg::NUM_POS; p++) begin
               wr[p] = 1'b1;
            end
            if (item.value > fdlcd_pkg::SHOW_LIMIT) begin
               for (int p = 0; p < fdlcd_pkg::NUM_POS; p++) begin
                  sym[p] = fdlcd_pkg::SYM_DASH;
               end
            end else begin
               // leading zeros blank, last position always a digit
               sym[0] = (dig0 == 4'd0) ? fdlcd_pkg::SYM_BLANK : dig0;
               sym[1] = ((dig0 | dig1) == 4'd0) ? fdlcd_pkg::SYM_BLANK : dig1;
               sym[2] = ((dig0 | dig1 | dig2) == 4'd0) ? fdlcd_pkg::SYM_BLANK : dig2;
               sym[3] = dig3;
            end
         end
         fdlcd_pkg::OP_CLEAR: begin
            for (int p = 0; p < fdlcd_pkg::NUM_POS; p++) begin
               wr[p] = 1'b1;
            end
         end
         fdlcd_pkg::OP_SET_CHARACTER: begin
            wr[item.position]  = 1'b1;
            sym[item.position] = char_sym;
         end
         default: begin
            wr[0] = 1'b0;
         end
      endcase
   end

   always_comb begin
      for (int c = 0; c < fdlcd_pkg::NUM_COM; c++) begin
         for (int p = 0; p < fdlcd_pkg::NUM_POS; p++) begin
            if (wr[p]) begin
               shadow_nxt[c][2*p +: 2] = fdlcd_pkg::seg_code(sym[p], 2'(c)) |
                  (pnt[p] ? fdlcd_pkg::seg_code(fdlcd_pkg::SYM_POINT, 2'(c)) : 2'h0);
            end else begin
               shadow_nxt[c][2*p +: 2] = shadow_cur[c][2*p +: 2];
            end
         end
      end
   end

endmodule

>>> sv/four_digit_segment_lcd_encoder_unit.sv
// ----------------------------------------------------------------------------
// four_digit_segment_lcd_encoder_unit
// shadow of a 4-digit, 4-com multiplexed segment lcd with pin waveform output
// ----------------------------------------------------------------------------
// Each request transaction is one operation on the display shadow (set digit,
// show number, clear, set character), and each one gives exactly one response
// transaction: the eight front-plane data pin waveforms of the shadow after
// the operation. The block takes one transaction per cycle while the output
// side is not stalled; a request is registered in the input stage, and its
// response in the shadow words. The rate is set by the shadow update, a
// single read-modify-write of the four shadow words per cycle; an input stage
// lets a new request in while a finished response still waits on the output
// side. Numbers above 9999 show four dashes, leading zeros of a number are
// blanked on the first three positions.
module four_digit_segment_lcd_encoder_unit (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // position[1:0], operand_value[17:2], dot[18], zero
   input  logic [1:0]  req_tuser,   // operation[1:0]
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // pin0_wave[3:0] up to pin7_wave[31:28]
);

   // input stage
   fdlcd_pkg::item_type   item_ff, item_in;
   logic                  item_valid_ff, item_valid_in;
   // shadow words, which also serve as the response register
   fdlcd_pkg::shadow_type shadow_ff, shadow_in;
   fdlcd_pkg::shadow_type shadow_nxt;
   logic                  rsp_valid_ff, rsp_valid_in;

   logic req_fire;
   logic out_free;
   logic item_go;

   // output register is free when empty or drained this cycle
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign item_go    = item_valid_ff && out_free;
   assign req_tready = !item_valid_ff || out_free;
   assign req_fire   = req_tvalid && req_tready;

   // unpack the request transaction
   always_comb begin
      item_in = item_ff;
      if (req_fire) begin
         item_in.op       = fdlcd_pkg::op_type'(req_tuser);
         item_in.position = req_tdata[1:0];
         item_in.value    = req_tdata[17:2];
         item_in.dot      = req_tdata[18];
      end
   end

   always_comb begin
      if (req_fire) begin
         item_valid_in = 1'b1;
      end else if (item_go) begin
         item_valid_in = 1'b0;
      end else begin
         item_valid_in = item_valid_ff;
      end
   end

   fdlcd_update u_update (
      .item       (item_ff),
      .shadow_cur (shadow_ff),
      .shadow_nxt (shadow_nxt)
   );

   // the shadow only moves when the response register can take it, so the
   // shadow and the pending response are always the same words
   assign shadow_in = item_go ? shadow_nxt : shadow_ff;

   always_comb begin
      if (item_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         shadow_ff     <= '0;
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         shadow_ff     <= shadow_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   // transpose: bit n of pin i is bit i of com word n
   always_comb begin
      for (int i = 0; i < fdlcd_pkg::WORD_W; i++) begin
         for (int n = 0; n < fdlcd_pkg::NUM_COM; n++) begin
            rsp_tdata[4*i + n] = shadow_ff[n][i];
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

>>> sv/fdlcd_checker.sv
// ----------------------------------------------------------------------------
// fdlcd_checker
// port level checks of the four digit lcd encoder, bound to the top level
// ----------------------------------------------------------------------------
module fdlcd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [1:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata
);

   // a stalled response holds its data
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   // nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // a request taken with an empty output side passes the input stage and shows up as a response
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !rsp_tvalid |=> ##1 rsp_tvalid)
      else $error("response missing after request");

   // a clear lands as an all-dark display
   a_clear_dark: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !rsp_tvalid &&
      req_tuser == fdlcd_pkg::OP_CLEAR ##1 rsp_tready
      |=> rsp_tvalid && rsp_tdata == 32'h0)
      else $error("clear did not blank the display");

endmodule

bind four_digit_segment_lcd_encoder_unit fdlcd_checker u_fdlcd_checker (.*);
